// ===== rtl/core/point_axis_rotation_macros.svh =====
// ----------------------------------------------------------------------------
// point_axis_rotation_macros
// assertion macros shared by the point rotation core
// ----------------------------------------------------------------------------
`ifndef POINT_AXIS_ROTATION_MACROS_SVH
`define POINT_AXIS_ROTATION_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PAR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PAR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/par_pkg.sv =====
// ----------------------------------------------------------------------------
// par_pkg
// shared types, codes and the degree sine table of the point rotation core
// ----------------------------------------------------------------------------
package par_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int SCREEN_BITS    = 13;
   localparam int PIVOT_BITS     = SCREEN_BITS - 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CMD_BITS       = 2;
   localparam int DEG_BITS       = 9;
   localparam int TABLE_IDX_BITS = 7;
   localparam int TABLE_BITS     = 17;
   localparam int TABLE_FRAC     = 16;

   localparam logic [DEG_BITS-1:0] QUARTER_TURN       = 9'd90;
   localparam logic [DEG_BITS-1:0] HALF_TURN          = 9'd180;
   localparam logic [DEG_BITS-1:0] THREE_QUARTER_TURN = 9'd270;
   localparam logic [DEG_BITS-1:0] FULL_TURN          = 9'd360;

   // floor(a / 360) for a <= 32768 as (a * RECIP_360) >> RECIP_SHIFT,
   // one less when a is a nonzero multiple of 360
   localparam logic [15:0] RECIP_360   = 16'd46603;
   localparam int          RECIP_SHIFT = 24;

   localparam logic [SCREEN_BITS-1:0] RESET_SCREEN_WIDTH  = 13'd1024;
   localparam logic [SCREEN_BITS-1:0] RESET_SCREEN_HEIGHT = 13'd768;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ABOUT_X = 2'd0,
      CMD_ABOUT_Y = 2'd1,
      CMD_ABOUT_Z = 2'd2,
      CMD_PASS    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ANGLE_X  = 3'd0,
      CSR_ANGLE_Y  = 3'd1,
      CSR_ANGLE_Z  = 3'd2,
      CSR_SCREEN_W = 3'd3,
      CSR_SCREEN_H = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle_x;
      logic signed [ANGLE_BITS-1:0] angle_y;
      logic signed [ANGLE_BITS-1:0] angle_z;
      logic [SCREEN_BITS-1:0]       width;
      logic [SCREEN_BITS-1:0]       height;
   } cfg_type;

   typedef struct packed {
      logic [TABLE_IDX_BITS-1:0] idx;
      logic                      neg;
   } trig_fold_type;

   // sin(d) for d = 0..90, Q1.16
   localparam logic [TABLE_BITS-1:0] SIN_Q16 [91] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
      17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
      17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
      17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
      17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
      17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
      17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
      17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
      17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
      17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
      17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

   function automatic logic [TABLE_BITS-1:0] sin_entry(logic [TABLE_IDX_BITS-1:0] idx);
      logic [TABLE_BITS-1:0] v;
      v = '0;
      if (idx <= TABLE_IDX_BITS'(QUARTER_TURN)) begin
         v = SIN_Q16[idx];
      end
      return v;
   endfunction

   // map a degree 0..359 onto the quarter-wave table and a sign
   function automatic trig_fold_type fold_angle(logic [DEG_BITS-1:0] deg);
      trig_fold_type f;
      if (deg <= QUARTER_TURN) begin
         f.idx = deg[TABLE_IDX_BITS-1:0];
         f.neg = 1'b0;
      end else if (deg <= HALF_TURN) begin
         f.idx = TABLE_IDX_BITS'(HALF_TURN - deg);
         f.neg = 1'b0;
      end else if (deg <= THREE_QUARTER_TURN) begin
         f.idx = TABLE_IDX_BITS'(deg - HALF_TURN);
         f.neg = 1'b1;
      end else begin
         f.idx = TABLE_IDX_BITS'(FULL_TURN - deg);
         f.neg = 1'b1;
      end
      return f;
   endfunction

endpackage

// ===== rtl/core/point_axis_rotation.sv =====
// ----------------------------------------------------------------------------
// point_axis_rotation
// rotates one 3d point per request about the x, y or z axis around the
// screen centre by a whole-degree angle held in configuration registers
// ----------------------------------------------------------------------------
// usage:
//   requests enter through req_push / req_full: cmd picks the axis (0 x,
//   1 y, 2 z, 3 pass through) and coord_x/y/z carry the point.
//   results leave through rsp_empty / rsp_pop, oldest first, one per request.
//   csr_wr_en writes csr_wr_data into register csr_index in the same edge:
//   0..2 angles about x, y, z in degrees, 3 screen width, 4 screen height.
// path: a request accepted into the first front stage passes the second front
//   stage, the middle queue, the two multiply/sum stages and the result queue
//   before it shows on the rsp ports.
// throughput: one request per cycle unless stalled; set by the front and back
//   pipelines, each stage holding one request, four multipliers in parallel.
// stalls: with rsp_pop low the result queue fills, the back end holds, the
//   middle queue fills and req_full rises; nothing is dropped.
// reset: angles return to 0, screen size to 1024 x 768, queues empty.
// ----------------------------------------------------------------------------
module point_axis_rotation import par_pkg::*; #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 16,
   parameter int QUEUE_DEPTH    = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [CMD_BITS-1:0]          req_cmd,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_rot_x,
   output logic signed [COORD_BITS-1:0] rsp_rot_y,
   output logic signed [COORD_BITS-1:0] rsp_rot_z,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wr_data
);

   localparam int DW   = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;
   localparam int TW   = TRIG_FRAC_BITS + 2;
   localparam int OP_W = CMD_BITS + 3*COORD_BITS + 2*PIVOT_BITS + 2*DW + 2*TW;
   localparam int RS_W = 3*COORD_BITS;

   cfg_type cfg_ff, cfg_in;

   logic            mid_push, mid_full, mid_pop, mid_empty;
   logic [OP_W-1:0] mid_push_data, mid_pop_data;
   logic            out_push, out_full;
   logic [RS_W-1:0] out_push_data, out_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ANGLE_X:  cfg_in.angle_x = csr_wr_data;
            CSR_ANGLE_Y:  cfg_in.angle_y = csr_wr_data;
            CSR_ANGLE_Z:  cfg_in.angle_z = csr_wr_data;
            CSR_SCREEN_W: cfg_in.width   = csr_wr_data[SCREEN_BITS-1:0];
            CSR_SCREEN_H: cfg_in.height  = csr_wr_data[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_x <= '0;
         cfg_ff.angle_y <= '0;
         cfg_ff.angle_z <= '0;
         cfg_ff.width   <= RESET_SCREEN_WIDTH;
         cfg_ff.height  <= RESET_SCREEN_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   par_front #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_cmd     (req_cmd),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .req_full    (req_full),
      .q_push      (mid_push),
      .q_data      (mid_push_data),
      .q_full      (mid_full)
   );

   par_fifo #(
      .WIDTH (OP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   par_back #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_pop    (mid_pop),
      .q_data   (mid_pop_data),
      .q_empty  (mid_empty),
      .out_push (out_push),
      .out_data (out_push_data),
      .out_full (out_full)
   );

   par_fifo #(
      .WIDTH (RS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_data),
      .full      (out_full),
      .pop       (rsp_pop && !rsp_empty),
      .pop_data  (out_pop_data),
      .empty     (rsp_empty)
   );

   assign {rsp_rot_x, rsp_rot_y, rsp_rot_z} = out_pop_data;

endmodule

// ===== rtl/core/par_fifo.sv =====
// ----------------------------------------------------------------------------
// par_fifo
// small register queue with count based full and empty flags
// ----------------------------------------------------------------------------
`include "point_axis_rotation_macros.svh"

module par_fifo import par_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PAR_ASSERT_IMPLY(a_fifo_no_overflow, clock, reset, push, !full, "push into full queue")
   `PAR_ASSERT_IMPLY(a_fifo_no_underflow, clock, reset, pop, !empty, "pop from empty queue")

endmodule

// ===== rtl/core/par_front.sv =====
// ----------------------------------------------------------------------------
// par_front
// accepts points, picks the axis operands, reduces the angle and looks up
// sine and cosine; hands one operation per point to the back end queue
// ----------------------------------------------------------------------------
`include "point_axis_rotation_macros.svh"

module par_front import par_pkg::*; #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         req_push,
   input  logic [CMD_BITS-1:0]          req_cmd,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   output logic                         req_full,
   output logic                         q_push,
   output logic [2*CMD_BITS/2+3*COORD_BITS+2*PIVOT_BITS
                 +2*(((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS)+1)
                 +2*(TRIG_FRAC_BITS+2)-1:0] q_data,
   input  logic                         q_full
);

   localparam int DW     = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;
   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int SH_DN  = (TRIG_FRAC_BITS <= TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
   localparam int SH_UP  = (TRIG_FRAC_BITS > TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
   localparam int ROUND  = (1 << SH_DN) >> 1;
   localparam int SCL_W  = TABLE_BITS + 9;
   localparam int Q_BITS = 8;

   typedef struct packed {
      cmd_type                      cmd;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [PIVOT_BITS-1:0]        pa;
      logic [PIVOT_BITS-1:0]        pb;
      logic signed [DW-1:0]         da;
      logic signed [DW-1:0]         db;
   } carry_type;

   typedef struct packed {
      carry_type            carry;
      logic signed [TW-1:0] s;
      logic signed [TW-1:0] c;
   } op_type;

   function automatic logic signed [TW-1:0] trig_value(trig_fold_type f);
      logic [SCL_W-1:0] t;
      logic [TW-1:0]    m;
      t = (SCL_W'(sin_entry(f.idx)) + SCL_W'(ROUND)) >> SH_DN;
      t = t << SH_UP;
      m = {1'b0, t[TRIG_FRAC_BITS:0]};
      return f.neg ? -$signed(m) : $signed(m);
   endfunction

   logic en;
   logic accept;

   // stage 1: operand select and reciprocal multiply
   logic                         f1_valid_ff;
   carry_type                    f1_carry_ff, f1_carry_in;
   logic [ANGLE_BITS-1:0]        f1_mag_ff, f1_mag_in;
   logic                         f1_neg_ff, f1_neg_in;
   logic [Q_BITS-1:0]            f1_q_ff, f1_q_in;
   logic signed [ANGLE_BITS-1:0] angle_sel;
   logic signed [COORD_BITS-1:0] a_sel, b_sel;
   logic [PIVOT_BITS-1:0]        px, py;
   logic [31:0]                  recip_prod;

   // stage 2: remainder and degree
   logic                  f2_valid_ff;
   carry_type             f2_carry_ff;
   logic [DEG_BITS-1:0]   f2_deg_ff, f2_deg_in;
   logic [ANGLE_BITS-1:0] rem_raw;
   logic [DEG_BITS-1:0]   rem_fix;

   // table lookup into the queue
   logic [DEG_BITS:0]   cos_sum;
   logic [DEG_BITS-1:0] cos_deg;
   op_type              op_in;

   assign en       = !f2_valid_ff || !q_full;
   assign req_full = !en;
   assign accept   = req_push && en;

   assign px = cfg.width[SCREEN_BITS-1:1];
   assign py = cfg.height[SCREEN_BITS-1:1];

   always_comb begin
      f1_carry_in.cmd = cmd_type'(req_cmd);
      f1_carry_in.x   = req_coord_x;
      f1_carry_in.y   = req_coord_y;
      f1_carry_in.z   = req_coord_z;
      unique case (cmd_type'(req_cmd))
         CMD_ABOUT_X: begin
            angle_sel = cfg.angle_x;
            a_sel = req_coord_y;
            b_sel = req_coord_z;
            f1_carry_in.pa = py;
            f1_carry_in.pb = '0;
         end
         CMD_ABOUT_Y: begin
            angle_sel = cfg.angle_y;
            a_sel = req_coord_z;
            b_sel = req_coord_x;
            f1_carry_in.pa = '0;
            f1_carry_in.pb = px;
         end
         CMD_ABOUT_Z: begin
            angle_sel = cfg.angle_z;
            a_sel = req_coord_x;
            b_sel = req_coord_y;
            f1_carry_in.pa = px;
            f1_carry_in.pb = py;
         end
         CMD_PASS: begin
            angle_sel = cfg.angle_x;
            a_sel = req_coord_x;
            b_sel = req_coord_y;
            f1_carry_in.pa = '0;
            f1_carry_in.pb = '0;
         end
         default: begin
            angle_sel = cfg.angle_x;
            a_sel = req_coord_x;
            b_sel = req_coord_y;
            f1_carry_in.pa = '0;
            f1_carry_in.pb = '0;
         end
      endcase
      f1_carry_in.da = DW'(a_sel) - $signed(DW'(f1_carry_in.pa));
      f1_carry_in.db = DW'(b_sel) - $signed(DW'(f1_carry_in.pb));
      f1_neg_in  = angle_sel[ANGLE_BITS-1];
      f1_mag_in  = f1_neg_in ? (~angle_sel + ANGLE_BITS'(1)) : angle_sel;
      recip_prod = 32'(f1_mag_in) * 32'(RECIP_360);
      f1_q_in    = recip_prod[RECIP_SHIFT +: Q_BITS];
   end

   // truncating remainder, negative side folded back into 0..359
   always_comb begin
      rem_raw = f1_mag_ff - ANGLE_BITS'(f1_q_ff) * ANGLE_BITS'(FULL_TURN);
      if (rem_raw >= ANGLE_BITS'(FULL_TURN)) begin
         rem_fix = DEG_BITS'(rem_raw - ANGLE_BITS'(FULL_TURN));
      end else begin
         rem_fix = rem_raw[DEG_BITS-1:0];
      end
      f2_deg_in = (f1_neg_ff && (rem_fix != '0)) ? FULL_TURN - rem_fix : rem_fix;
   end

   always_comb begin
      cos_sum = {1'b0, f2_deg_ff} + (DEG_BITS+1)'(QUARTER_TURN);
      if (cos_sum >= (DEG_BITS+1)'(FULL_TURN)) begin
         cos_deg = DEG_BITS'(cos_sum - (DEG_BITS+1)'(FULL_TURN));
      end else begin
         cos_deg = cos_sum[DEG_BITS-1:0];
      end
      op_in.carry = f2_carry_ff;
      op_in.s     = trig_value(fold_angle(f2_deg_ff));
      op_in.c     = trig_value(fold_angle(cos_deg));
   end

   assign q_push = f2_valid_ff && !q_full;
   assign q_data = op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_carry_ff <= f1_carry_in;
         f1_mag_ff   <= f1_mag_in;
         f1_neg_ff   <= f1_neg_in;
         f1_q_ff     <= f1_q_in;
         f2_carry_ff <= f1_carry_ff;
         f2_deg_ff   <= f2_deg_in;
      end
   end

   `PAR_ASSERT_NEXT(a_front_stall_holds, clock, reset, req_full,
      f2_valid_ff && $stable(f2_deg_ff), "front stage moved while stalled")
   `PAR_ASSERT_IMPLY(a_front_deg_range, clock, reset, f2_valid_ff,
      f2_deg_ff < FULL_TURN, "reduced angle out of range")

endmodule

// ===== rtl/core/par_back.sv =====
// ----------------------------------------------------------------------------
// par_back
// takes queued operations, forms the rotation products and sums, truncates
// toward zero, saturates and writes the point into the result queue
// ----------------------------------------------------------------------------
`include "point_axis_rotation_macros.svh"

module par_back import par_pkg::*; #(
   parameter int COORD_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    q_pop,
   input  logic [2*CMD_BITS/2+3*COORD_BITS+2*PIVOT_BITS
                 +2*(((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS)+1)
                 +2*(TRIG_FRAC_BITS+2)-1:0] q_data,
   input  logic                    q_empty,
   output logic                    out_push,
   output logic [3*COORD_BITS-1:0] out_data,
   input  logic                    out_full
);

   localparam int DW = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = DW + TW;
   localparam int SW = PW + 2;

   localparam logic signed [SW-1:0] SAT_MAX =
      $signed({{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_MIN =
      $signed({{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

   typedef struct packed {
      cmd_type                      cmd;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [PIVOT_BITS-1:0]        pa;
      logic [PIVOT_BITS-1:0]        pb;
      logic signed [DW-1:0]         da;
      logic signed [DW-1:0]         db;
      logic signed [TW-1:0]         s;
      logic signed [TW-1:0]         c;
   } op_type;

   // divide by 2^frac truncating toward zero, then clamp
   function automatic logic signed [COORD_BITS-1:0] finish(logic signed [SW-1:0] sum);
      logic signed [SW-1:0] q;
      q = sum >>> TRIG_FRAC_BITS;
      if (sum[SW-1] && (|sum[TRIG_FRAC_BITS-1:0])) begin
         q = q + SW'(1);
      end
      if (q > SAT_MAX) begin
         q = SAT_MAX;
      end else if (q < SAT_MIN) begin
         q = SAT_MIN;
      end
      return q[COORD_BITS-1:0];
   endfunction

   op_type op;
   logic   en;

   // stage 1: products
   logic                         b1_valid_ff;
   cmd_type                      b1_cmd_ff;
   logic signed [COORD_BITS-1:0] b1_x_ff, b1_y_ff, b1_z_ff;
   logic [PIVOT_BITS-1:0]        b1_pa_ff, b1_pb_ff;
   logic signed [PW-1:0]         b1_pac_ff, b1_pac_in;
   logic signed [PW-1:0]         b1_pbs_ff, b1_pbs_in;
   logic signed [PW-1:0]         b1_pas_ff, b1_pas_in;
   logic signed [PW-1:0]         b1_pbc_ff, b1_pbc_in;

   // stage 2: sums
   logic                         b2_valid_ff;
   cmd_type                      b2_cmd_ff;
   logic signed [COORD_BITS-1:0] b2_x_ff, b2_y_ff, b2_z_ff;
   logic signed [SW-1:0]         b2_sa_ff, b2_sa_in;
   logic signed [SW-1:0]         b2_sb_ff, b2_sb_in;
   logic signed [SW-1:0]         pa_scaled, pb_scaled;

   logic signed [COORD_BITS-1:0] fa, fb;
   logic signed [COORD_BITS-1:0] rot_x, rot_y, rot_z;

   assign op    = q_data;
   assign en    = !b2_valid_ff || !out_full;
   assign q_pop = en && !q_empty;

   assign b1_pac_in = PW'(op.da) * PW'(op.c);
   assign b1_pbs_in = PW'(op.db) * PW'(op.s);
   assign b1_pas_in = PW'(op.da) * PW'(op.s);
   assign b1_pbc_in = PW'(op.db) * PW'(op.c);

   // pivot moved back in at full fraction scale before truncation
   assign pa_scaled = $signed(SW'({b1_pa_ff, {TRIG_FRAC_BITS{1'b0}}}));
   assign pb_scaled = $signed(SW'({b1_pb_ff, {TRIG_FRAC_BITS{1'b0}}}));
   assign b2_sa_in  = SW'(b1_pac_ff) - SW'(b1_pbs_ff) + pa_scaled;
   assign b2_sb_in  = SW'(b1_pas_ff) + SW'(b1_pbc_ff) + pb_scaled;

   assign fa = finish(b2_sa_ff);
   assign fb = finish(b2_sb_ff);

   always_comb begin
      unique case (b2_cmd_ff)
         CMD_ABOUT_X: begin
            rot_x = b2_x_ff;
            rot_y = fa;
            rot_z = fb;
         end
         CMD_ABOUT_Y: begin
            rot_x = fb;
            rot_y = b2_y_ff;
            rot_z = fa;
         end
         CMD_ABOUT_Z: begin
            rot_x = fa;
            rot_y = fb;
            rot_z = b2_z_ff;
         end
         CMD_PASS: begin
            rot_x = b2_x_ff;
            rot_y = b2_y_ff;
            rot_z = b2_z_ff;
         end
         default: begin
            rot_x = b2_x_ff;
            rot_y = b2_y_ff;
            rot_z = b2_z_ff;
         end
      endcase
   end

   assign out_push = b2_valid_ff && !out_full;
   assign out_data = {rot_x, rot_y, rot_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= !q_empty;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_cmd_ff <= op.cmd;
         b1_x_ff   <= op.x;
         b1_y_ff   <= op.y;
         b1_z_ff   <= op.z;
         b1_pa_ff  <= op.pa;
         b1_pb_ff  <= op.pb;
         b1_pac_ff <= b1_pac_in;
         b1_pbs_ff <= b1_pbs_in;
         b1_pas_ff <= b1_pas_in;
         b1_pbc_ff <= b1_pbc_in;
         b2_cmd_ff <= b1_cmd_ff;
         b2_x_ff   <= b1_x_ff;
         b2_y_ff   <= b1_y_ff;
         b2_z_ff   <= b1_z_ff;
         b2_sa_ff  <= b2_sa_in;
         b2_sb_ff  <= b2_sb_in;
      end
   end

   `PAR_ASSERT_NEXT(a_back_stall_holds, clock, reset, b2_valid_ff && out_full,
      b2_valid_ff && $stable(b2_sa_ff) && $stable(b2_sb_ff), "back stage moved while stalled")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for point_axis_rotation: random points and axis
// commands under a series of angle and screen settings, each result checked
// against a behavioral rotation predictor with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench import par_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W        = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint Q16_ONE    = 64'sd65536;

   typedef struct {
      cmd_type                   cmd;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_request_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } rotated_point_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic [CMD_BITS-1:0]          req_cmd = CMD_ABOUT_X;
   logic signed [COORD_W-1:0]    req_coord_x = '0;
   logic signed [COORD_W-1:0]    req_coord_y = '0;
   logic signed [COORD_W-1:0]    req_coord_z = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic signed [COORD_W-1:0]    rsp_rot_x;
   logic signed [COORD_W-1:0]    rsp_rot_y;
   logic signed [COORD_W-1:0]    rsp_rot_z;
   logic                         csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wr_data;

   point_request_type points_to_send [$];
   rotated_point_type rotated_points_due [$];

   // copy of the register file as the predictor sees it
   logic signed [ANGLE_BITS-1:0] angle_copy [3];
   logic [SCREEN_BITS-1:0]       width_copy;
   logic [SCREEN_BITS-1:0]       height_copy;

   int  mismatches      = 0;
   int  results_checked = 0;
   int  idle_cycles     = 0;
   int  send_gap        = 0;
   int  pop_gap         = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  no_idle;
   bit  req_accepted    = 1'b0;

   // sin(d) for d = 0..90 in q1.16
   int sine_q16 [0:90] = '{
      0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
      11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
      22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
      32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
      42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
      50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
      56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
      61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
      64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
      65536
   };

   point_axis_rotation u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cmd     (req_cmd),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_rot_x   (rsp_rot_x),
      .rsp_rot_y   (rsp_rot_y),
      .rsp_rot_z   (rsp_rot_z),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint sine_deg(int d);
      if (d <= 90) return longint'(sine_q16[d]);
      if (d <= 180) return longint'(sine_q16[180 - d]);
      if (d <= 270) return -longint'(sine_q16[d - 180]);
      return -longint'(sine_q16[360 - d]);
   endfunction

   function automatic logic signed [COORD_W-1:0] saturate_coord(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[COORD_W-1:0];
   endfunction

   // turn (a, b) about (pa, pb); longint division truncates toward zero
   function automatic void turn_pair(inout longint a, inout longint b,
                                     input longint pa, input longint pb,
                                     input int angle);
      int     deg;
      longint s;
      longint c;
      longint da;
      longint db;
      deg = angle % 360;
      if (deg < 0) deg = deg + 360;
      s  = sine_deg(deg);
      c  = sine_deg((deg + 90) % 360);
      da = a - pa;
      db = b - pb;
      a  = longint'(saturate_coord((da * c - db * s + pa * Q16_ONE) / Q16_ONE));
      b  = longint'(saturate_coord((da * s + db * c + pb * Q16_ONE) / Q16_ONE));
   endfunction

   function automatic rotated_point_type rotate_point(point_request_type p);
      rotated_point_type r;
      longint x;
      longint y;
      longint z;
      longint px;
      longint py;
      x  = longint'(p.x);
      y  = longint'(p.y);
      z  = longint'(p.z);
      px = longint'(width_copy >> 1);
      py = longint'(height_copy >> 1);
      unique case (p.cmd)
         CMD_ABOUT_X: turn_pair(y, z, py, 0, int'(angle_copy[0]));
         CMD_ABOUT_Y: turn_pair(z, x, 0, px, int'(angle_copy[1]));
         CMD_ABOUT_Z: turn_pair(x, y, px, py, int'(angle_copy[2]));
         default: ;
      endcase
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.z = z[COORD_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- monitor

   task automatic check_field(string name, logic signed [COORD_W-1:0] want,
                              logic signed [COORD_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rotated_point_type due;
      point_request_type seen;
      req_accepted = !reset && req_push && !req_full;
      if (req_accepted) begin
         seen.cmd = cmd_type'(req_cmd);
         seen.x   = req_coord_x;
         seen.y   = req_coord_y;
         seen.z   = req_coord_z;
         rotated_points_due.push_back(rotate_point(seen));
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rotated_points_due.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual %0d %0d %0d",
                     $time, rsp_rot_x, rsp_rot_y, rsp_rot_z);
         end else begin
            due = rotated_points_due.pop_front();
            check_field("rot_x", due.x, rsp_rot_x);
            check_field("rot_y", due.y, rsp_rot_y);
            check_field("rot_z", due.z, rsp_rot_z);
         end
         results_checked++;
         idle_cycles = 0;
      end else if (req_accepted || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_accepted) begin
            void'(points_to_send.pop_front());
            send_gap = no_idle ? 0 : idle_length();
         end
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (points_to_send.size() > 0) begin
            req_push    <= 1'b1;
            req_cmd     <= points_to_send[0].cmd;
            req_coord_x <= points_to_send[0].x;
            req_coord_y <= points_to_send[0].y;
            req_coord_z <= points_to_send[0].z;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (!hold_done && results_checked >= 300) begin
         // long receiver hold-off so the queues fill and req_full rises
         hold_done = 1'b1;
         hold_left = 250;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         pop_gap = no_idle ? 0 : idle_length();
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      unique case (idx)
         CSR_ANGLE_X:  angle_copy[0] = value;
         CSR_ANGLE_Y:  angle_copy[1] = value;
         CSR_ANGLE_Z:  angle_copy[2] = value;
         CSR_SCREEN_W: width_copy = value[SCREEN_BITS-1:0];
         CSR_SCREEN_H: height_copy = value[SCREEN_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_point(cmd_type cmd, int x, int y, int z);
      point_request_type p;
      p.cmd = cmd;
      p.x   = x[COORD_W-1:0];
      p.y   = y[COORD_W-1:0];
      p.z   = z[COORD_W-1:0];
      points_to_send.push_back(p);
   endtask

   function automatic int random_coord();
      int r;
      logic [COORD_W-1:0] raw;
      r   = $urandom_range(0, 99);
      raw = COORD_W'($urandom);
      if (r < 35) return int'($signed(raw));
      if (r < 85) return int'($urandom_range(0, 4000)) - 2000;
      unique case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_angle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CSR_DATA_BITS'($urandom);
      if (r < 75) return CSR_DATA_BITS'($urandom_range(0, 1440) - 720);
      return CSR_DATA_BITS'(90 * ($urandom_range(0, 16) - 8));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_screen();
      unique case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd8191;
         2: return CSR_DATA_BITS'($urandom);
         default: return CSR_DATA_BITS'($urandom_range(200, 2000));
      endcase
   endfunction

   task automatic queue_random_points(int count);
      int r;
      @(posedge clock);
      repeat (count) begin
         r = $urandom_range(0, 9);
         queue_point(cmd_type'(r < 3 ? CMD_ABOUT_X : r < 6 ? CMD_ABOUT_Y :
                               r < 9 ? CMD_ABOUT_Z : CMD_PASS),
                     random_coord(), random_coord(), random_coord());
      end
   endtask

   task automatic wait_drained();
      while (points_to_send.size() != 0 || req_push || rotated_points_due.size() != 0)
         @(posedge clock);
      // pipeline depth plus a margin
      repeat (8) @(posedge clock);
   endtask

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_ANGLE_X;
      csr_wr_data     = '0;
      angle_copy[0]   = '0;
      angle_copy[1]   = '0;
      angle_copy[2]   = '0;
      width_copy      = 13'd1024;
      height_copy     = 13'd768;
      no_idle         = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register values straight out of reset
      queue_random_points(60);
      wait_drained();

      // directed: negative angle, half turn, eighth turn, extreme screen sizes
      set_register(CSR_ANGLE_X, -16'sd270);
      set_register(CSR_ANGLE_Y, 16'sd180);
      set_register(CSR_ANGLE_Z, 16'sd45);
      set_register(CSR_SCREEN_W, 16'd8191);
      set_register(CSR_SCREEN_H, 16'd0);
      @(posedge clock);
      queue_point(CMD_ABOUT_X, 0, 0, 0);
      queue_point(CMD_ABOUT_X, 32767, 32767, 32767);
      queue_point(CMD_ABOUT_X, -32768, -32768, -32768);
      queue_point(CMD_ABOUT_X, 100, -200, 300);
      queue_point(CMD_ABOUT_Y, 0, 0, 0);
      queue_point(CMD_ABOUT_Y, 32767, 32767, 32767);
      queue_point(CMD_ABOUT_Y, -32768, -32768, -32768);
      queue_point(CMD_ABOUT_Y, 100, -200, 300);
      queue_point(CMD_ABOUT_Z, 0, 0, 0);
      // sum beyond the coordinate range saturates
      queue_point(CMD_ABOUT_Z, 32767, 32767, 5);
      queue_point(CMD_ABOUT_Z, -32768, -32768, -5);
      queue_point(CMD_ABOUT_Z, -32768, 32767, 32767);
      queue_point(CMD_ABOUT_Z, 4095, 0, -32768);
      // pass command passes the point through
      queue_point(CMD_PASS, 32767, -32768, 0);
      queue_point(CMD_PASS, -1, 1, -1);
      queue_point(CMD_PASS, -32768, 32767, -32768);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 0) begin
            set_register(CSR_ANGLE_X, 16'h8000);
            set_register(CSR_ANGLE_Y, 16'h8000);
            set_register(CSR_ANGLE_Z, 16'h8000);
            set_register(CSR_SCREEN_W, 16'd0);
            set_register(CSR_SCREEN_H, 16'd0);
         end else if (phase == 1) begin
            set_register(CSR_ANGLE_X, 16'h7fff);
            set_register(CSR_ANGLE_Y, 16'h7fff);
            set_register(CSR_ANGLE_Z, 16'h7fff);
            set_register(CSR_SCREEN_W, 16'd8191);
            set_register(CSR_SCREEN_H, 16'd8191);
         end else begin
            set_register(CSR_ANGLE_X, random_angle());
            set_register(CSR_ANGLE_Y, random_angle());
            set_register(CSR_ANGLE_Z, random_angle());
            set_register(CSR_SCREEN_W, random_screen());
            set_register(CSR_SCREEN_H, random_screen());
         end
         // back-to-back stretch with no idling on either side
         no_idle = (phase == 4);
         queue_random_points(95);
         wait_drained();
      end
      no_idle = 1'b0;

      if (mismatches == 0 && rotated_points_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== point_axis_rotation.f =====
+incdir+rtl/core
rtl/core/par_pkg.sv
rtl/core/par_fifo.sv
rtl/core/par_front.sv
rtl/core/par_back.sv
rtl/core/point_axis_rotation.sv
tb/testbench.sv
